// File: rtl/life_automaton_torus_core_macros.svh
// Assertion macros used by the life automaton core RTL
`ifndef LIFE_AUTOMATON_TORUS_CORE_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define LAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define LAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lat_pkg.sv
// Package: types and constants of the life automaton core
`timescale 1ns / 1ps
package lat_pkg;

  localparam int MAX_SIDE_DEF = 64;
  localparam int GRID_SIZE_W  = 7;
  localparam int REQ_W        = 2;
  localparam int COORD_W      = 6;
  localparam int MIN_SIDE     = 3;
  localparam int NB_W         = 4;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 7'd64;

  localparam logic [NB_W-1:0] NB_BIRTH = 4'd3;
  localparam logic [NB_W-1:0] NB_KEEP  = 4'd2;

  localparam logic ANS_READ = 1'b0;
  localparam logic ANS_STEP = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_STEP = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIX,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } lat_cell_ctrl_t;

endpackage

// File: rtl/lat_req_if.sv
// Interface: request channel of the life automaton core
`timescale 1ns / 1ps
interface lat_req_if;
  import lat_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [COORD_W-1:0]   col;
  logic [COORD_W-1:0]   row;
  logic                 cell_value;

  modport source (output valid, output req_type, output col, output row, output cell_value,
                  input ready);
  modport sink   (input valid, input req_type, input col, input row, input cell_value,
                  output ready);
endinterface

// File: rtl/lat_ans_if.sv
// Interface: answer channel of the life automaton core
`timescale 1ns / 1ps
interface lat_ans_if;
  import lat_pkg::*;

  logic valid;
  logic ready;
  logic answer_kind;
  logic cell_state;

  modport source (output valid, output answer_kind, output cell_state, input ready);
  modport sink   (input valid, input answer_kind, input cell_state, output ready);
endinterface

// File: rtl/lat_row_cell.sv
// One cell of the row ring: holds one grid row, takes its neighbour's row on a shift
`timescale 1ns / 1ps
module lat_row_cell #(
  parameter int W = lat_pkg::MAX_SIDE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lat_pkg::lat_cell_ctrl_t ctrl_i,
  input  logic [W-1:0]           next_i,
  input  logic [W-1:0]           load_i,
  output logic [W-1:0]           row_o
);
  import lat_pkg::*;

  logic [W-1:0] row_q;
  logic [W-1:0] row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.load) begin
      row_d = load_i;
    end else if (ctrl_i.shift) begin
      row_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;
endmodule

// File: rtl/lat_rule.sv
// Next-generation row under B3/S23 with wrap at the side in use
`timescale 1ns / 1ps
module lat_rule #(
  parameter int W    = lat_pkg::MAX_SIDE_DEF,
  parameter int IDXW = 6
) (
  input  logic [W-1:0]    prev_i,
  input  logic [W-1:0]    cur_i,
  input  logic [W-1:0]    next_i,
  input  logic [IDXW-1:0] last_i,
  output logic [W-1:0]    row_o
);
  import lat_pkg::*;

  logic p_last;
  logic c_last;
  logic n_last;

  assign p_last = prev_i[last_i];
  assign c_last = cur_i[last_i];
  assign n_last = next_i[last_i];

  for (genvar c = 0; c < W; c++) begin : g_col
    localparam int CR = (c == W - 1) ? 0 : c + 1;
    logic            at_last;
    logic            pl, cl, nl;
    logic            pr, cr, nr;
    logic [NB_W-1:0] sum;

    assign at_last = (last_i == IDXW'(c));

    if (c == 0) begin : g_first
      assign pl = p_last;
      assign cl = c_last;
      assign nl = n_last;
    end else begin : g_inner
      assign pl = prev_i[c-1];
      assign cl = cur_i[c-1];
      assign nl = next_i[c-1];
    end

    assign pr = at_last ? prev_i[0] : prev_i[CR];
    assign cr = at_last ? cur_i[0]  : cur_i[CR];
    assign nr = at_last ? next_i[0] : next_i[CR];

    assign sum = NB_W'(pl) + NB_W'(prev_i[c]) + NB_W'(pr)
               + NB_W'(cl) + NB_W'(cr)
               + NB_W'(nl) + NB_W'(next_i[c]) + NB_W'(nr);

    assign row_o[c] = (IDXW'(c) <= last_i)
                    ? ((sum == NB_BIRTH) || (cur_i[c] && (sum == NB_KEEP)))
                    : cur_i[c];
  end
endmodule

// File: rtl/life_automaton_torus_core.sv
// Top level: toroidal B3/S23 life grid held in a ring of row cells
//
//  channel   | dir | transfer when       | payload
//  ----------+-----+---------------------+----------------------------------
//  req       | in  | req.valid & ready   | req_type, col, row, cell_value
//  ans       | out | ans.valid & ready   | answer_kind, cell_state
//  cfg       | in  | cfg_we_i            | grid_size (cfg_wdata_i)
//
//  Every load, read or step rotates the whole ring of MAX_SIDE rows once, one row a cycle.
//  After the sweep a load is done; a read waits in HOLD; a step fixes row 0 in FIX, then waits in HOLD.
//  Ignored requests are taken and leave the core idle. Requests are taken only in ST_IDLE, not in SWEEP, FIX or HOLD.
//  A finished answer waits in the output register; the next request is taken meanwhile.
//  Reset clears the whole grid at once and sets the side to 64.
`timescale 1ns / 1ps
module life_automaton_torus_core #(
  parameter int MAX_SIDE = lat_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lat_pkg::GRID_SIZE_W-1:0] cfg_wdata_i,
  lat_req_if.sink                         req,
  lat_ans_if.source                       ans
);
  import lat_pkg::*;

`include "life_automaton_torus_core_macros.svh"

  localparam int IDXW  = $clog2(MAX_SIDE);
  localparam int SIDEW = $clog2(MAX_SIDE + 1);
  localparam int CW0   = (SIDEW > GRID_SIZE_W) ? SIDEW : GRID_SIZE_W;
  localparam int CMPW  = (CW0 > COORD_W) ? CW0 : COORD_W;
  localparam logic [IDXW-1:0] CNT_LAST = IDXW'(MAX_SIDE - 1);

  state_e                 state_q, state_d;
  logic [IDXW-1:0]        cnt_q, cnt_d;
  logic [GRID_SIZE_W-1:0] grid_size_q;
  req_e                   op_q;
  logic [IDXW-1:0]        row_q, col_q, last_q;
  logic                   val_q;
  logic [MAX_SIDE-1:0]    prev_q, first_q, second_q, new0_q;
  logic                   rd_bit_q;
  logic                   out_valid_q, out_kind_q, out_state_q;

  logic [CMPW-1:0]        gs_ext, side_c;
  logic [IDXW-1:0]        last_d;
  logic                   coord_ok;
  logic                   accept;
  logic                   out_load;
  logic                   hold_free;

  logic [MAX_SIDE-1:0]    row_w [MAX_SIDE];
  logic [MAX_SIDE-1:0]    head, tail, nxt_a, rule_a, rule_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RST;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    gs_ext = CMPW'(grid_size_q);
    side_c = gs_ext;
    if (gs_ext < CMPW'(MIN_SIDE)) begin
      side_c = CMPW'(MIN_SIDE);
    end else if (gs_ext > CMPW'(MAX_SIDE)) begin
      side_c = CMPW'(MAX_SIDE);
    end
    last_d   = IDXW'(side_c - CMPW'(1));
    coord_ok = (CMPW'(req.row) < side_c) && (CMPW'(req.col) < side_c);
  end

  assign req.ready = (state_q == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign hold_free = !out_valid_q || ans.ready;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          cnt_d = '0;
          unique case (req_e'(req.req_type)) inside
            REQ_STEP: state_d = ST_SWEEP;
            REQ_LOAD, REQ_READ: begin
              if (coord_ok) begin
                state_d = ST_SWEEP;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          unique case (op_q)
            REQ_STEP: state_d = ST_FIX;
            REQ_READ: state_d = ST_HOLD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_FIX: state_d = ST_HOLD;
      ST_HOLD: begin
        if (hold_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign head = row_w[0];

  for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
    lat_cell_ctrl_t      ctrl;
    logic [MAX_SIDE-1:0] nxt;

    assign ctrl.shift = (state_q == ST_SWEEP);
    assign ctrl.load  = (k == 0) && (state_q == ST_FIX);

    if (k == MAX_SIDE - 1) begin : g_tail
      assign nxt = tail;
    end else begin : g_link
      assign nxt = row_w[k+1];
    end

    lat_row_cell #(
      .W (MAX_SIDE)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .next_i (nxt),
      .load_i (new0_q),
      .row_o  (row_w[k])
    );
  end

  assign nxt_a = (cnt_q == last_q) ? first_q : row_w[1];

  lat_rule #(
    .W    (MAX_SIDE),
    .IDXW (IDXW)
  ) u_rule_a (
    .prev_i (prev_q),
    .cur_i  (head),
    .next_i (nxt_a),
    .last_i (last_q),
    .row_o  (rule_a)
  );

  lat_rule #(
    .W    (MAX_SIDE),
    .IDXW (IDXW)
  ) u_rule_b (
    .prev_i (head),
    .cur_i  (first_q),
    .next_i (second_q),
    .last_i (last_q),
    .row_o  (rule_b)
  );

  always_comb begin
    tail = head;
    if ((op_q == REQ_STEP) && (cnt_q != '0) && (cnt_q <= last_q)) begin
      tail = rule_a;
    end
    if ((op_q == REQ_LOAD) && (cnt_q == row_q)) begin
      tail[col_q] = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_e'(req.req_type);
      row_q  <= IDXW'(req.row);
      col_q  <= IDXW'(req.col);
      val_q  <= req.cell_value;
      last_q <= last_d;
    end
    if (state_q == ST_SWEEP) begin
      prev_q <= head;
      if (cnt_q == '0) begin
        first_q <= head;
      end
      if (cnt_q == IDXW'(1)) begin
        second_q <= head;
      end
      if (cnt_q == last_q) begin
        new0_q <= rule_b;
      end
      if ((op_q == REQ_READ) && (cnt_q == row_q)) begin
        rd_bit_q <= head[col_q];
      end
    end
    if (out_load) begin
      out_kind_q  <= (op_q == REQ_STEP) ? ANS_STEP : ANS_READ;
      out_state_q <= (op_q == REQ_STEP) ? 1'b0 : rd_bit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (ans.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign ans.valid       = out_valid_q;
  assign ans.answer_kind = out_kind_q;
  assign ans.cell_state  = out_state_q;

  `LAT_ASSERT_NEXT(a_sweep_count, (state_q == ST_SWEEP) && (cnt_q != CNT_LAST),
    (state_q == ST_SWEEP) && (cnt_q == IDXW'($past(cnt_q) + 1'b1)), "sweep count slipped")
  `LAT_ASSERT_NEXT(a_step_fix, (state_q == ST_SWEEP) && (cnt_q == CNT_LAST) && (op_q == REQ_STEP),
    state_q == ST_FIX, "step sweep did not fix row 0")
  `LAT_ASSERT_NEXT(a_hold_wait, (state_q == ST_HOLD) && out_valid_q && !ans.ready,
    (state_q == ST_HOLD) && out_valid_q, "answer overwritten while waiting")
  `LAT_ASSERT_NOW(a_step_zero, ans.valid && (ans.answer_kind == ANS_STEP),
    !ans.cell_state, "step answer carries a live cell")
endmodule

// File: sim/life_automaton_torus_core_checker.sv
// Checker: predicts the life grid answers and compares every answer transfer
`timescale 1ns / 1ps
module life_automaton_torus_core_checker
  import lat_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [GRID_SIZE_W-1:0] cfg_wdata_i,
  lat_req_if                     req,
  lat_ans_if                     ans,
  output int                     errors_o,
  output int                     pending_o,
  output int                     side_o
);

  typedef struct packed {
    logic kind;
    logic state;
  } answer_t;

  logic [MAX_SIDE-1:0] cells_q [MAX_SIDE];
  answer_t             answers_due [$];
  int unsigned         side_q;
  int                  errors_q = 0;

  function automatic int unsigned clamp_side(logic [GRID_SIZE_W-1:0] v);
    if (v < MIN_SIDE) return MIN_SIDE;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    errors_q++;
  endtask

  task automatic advance_generation();
    logic [MAX_SIDE-1:0] nxt [MAX_SIDE];
    int unsigned         k;
    for (int unsigned r = 0; r < side_q; r++) begin
      for (int unsigned c = 0; c < side_q; c++) begin
        k = 0;
        for (int unsigned dr = 0; dr < 3; dr++) begin
          for (int unsigned dc = 0; dc < 3; dc++) begin
            if (dr != 1 || dc != 1)
              k += cells_q[(r + side_q + dr - 1) % side_q][(c + side_q + dc - 1) % side_q];
          end
        end
        nxt[r][c] = cells_q[r][c] ? (k == NB_KEEP || k == NB_BIRTH) : (k == NB_BIRTH);
      end
    end
    for (int unsigned r = 0; r < side_q; r++)
      for (int unsigned c = 0; c < side_q; c++)
        cells_q[r][c] = nxt[r][c];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t due;
    if (!rst_ni) begin
      for (int r = 0; r < MAX_SIDE; r++) cells_q[r] = '0;
      answers_due.delete();
      side_q = clamp_side(GRID_SIZE_RST);
    end else begin
      // retire the answer first: it always belongs to an older request
      if (ans.valid && ans.ready) begin
        if (answers_due.size() == 0) begin
          report($sformatf("answer with none due: kind %0b state %0b",
                           ans.answer_kind, ans.cell_state));
        end else begin
          due = answers_due.pop_front();
          if (ans.answer_kind !== due.kind)
            report($sformatf("answer_kind expected %0b got %0b", due.kind, ans.answer_kind));
          if (ans.cell_state !== due.state)
            report($sformatf("cell_state expected %0b got %0b", due.state, ans.cell_state));
        end
      end
      if (cfg_we_i) side_q = clamp_side(cfg_wdata_i);
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_LOAD: begin
            if (req.col < side_q && req.row < side_q) cells_q[req.row][req.col] = req.cell_value;
          end
          REQ_STEP: begin
            advance_generation();
            answers_due.push_back('{kind: ANS_STEP, state: 1'b0});
          end
          REQ_READ: begin
            if (req.col < side_q && req.row < side_q)
              answers_due.push_back('{kind: ANS_READ, state: cells_q[req.row][req.col]});
          end
          default: ;
        endcase
      end
    end
    pending_o <= answers_due.size();
    side_o    <= side_q;
    errors_o  <= errors_q;
  end

endmodule

// File: sim/life_automaton_torus_core_test.sv
// Testbench top: drives requests, grid sizes and answer back-pressure, gives the verdict
`timescale 1ns / 1ps
module life_automaton_torus_core_test;
  import lat_pkg::*;

  localparam int               MAX_SIDE     = MAX_SIDE_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;
  localparam int               PHASE_ITEMS  = 80;
  localparam int               HOLD_CYCLES  = 400;
  localparam int               DRAIN_CYCLES = MAX_SIDE + 16;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [GRID_SIZE_W-1:0] cfg_wdata_i;
  int                     errors;
  int                     pending;
  int                     side;
  bit                     no_idle;
  bit                     hold_answers;
  int unsigned            useful_items;

  logic [GRID_SIZE_W-1:0] phase_sides [10] = '{3, 0, 127, 5, 1, 17, 64, 2, 100, 8};

  lat_req_if req ();
  lat_ans_if ans ();

  life_automaton_torus_core #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .ans         (ans)
  );

  life_automaton_torus_core_checker #(.MAX_SIDE(MAX_SIDE)) grid_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .ans         (ans),
    .errors_o    (errors),
    .pending_o   (pending),
    .side_o      (side)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic send(logic [REQ_W-1:0] kind, int unsigned c, int unsigned r, logic v);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.col        <= c[COORD_W-1:0];
    req.row        <= r[COORD_W-1:0];
    req.cell_value <= v;
    do @(posedge clk_i); while (!req.ready);
    if (kind == REQ_STEP || (kind != REQ_UNUSED && c < side && r < side)) useful_items++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_side(logic [GRID_SIZE_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic int unsigned near(int unsigned base);
    int unsigned span;
    span = (side < 6) ? side : 6;
    return (base + $urandom_range(0, span - 1)) % side;
  endfunction

  function automatic int unsigned pick_base();
    if ($urandom_range(0, 1)) return side - $urandom_range(1, 2);
    return $urandom_range(0, side - 1);
  endfunction

  task automatic pattern_burst();
    int unsigned bc;
    int unsigned br;
    bc = pick_base();
    br = pick_base();
    repeat ($urandom_range(3, 10)) send(REQ_LOAD, near(bc), near(br), $urandom_range(0, 3) != 0);
    repeat ($urandom_range(1, 3)) send(REQ_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 1));
    repeat ($urandom_range(3, 8)) send(REQ_READ, near(bc), near(br), $urandom_range(0, 1));
  endtask

  task automatic noise_item();
    int unsigned c;
    int unsigned r;
    c = $urandom_range(0, 63);
    r = $urandom_range(0, 63);
    if (side < 64 && $urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1)) c = $urandom_range(side, 63);
      else r = $urandom_range(side, 63);
      send($urandom_range(0, 1) ? REQ_LOAD : REQ_READ, c, r, $urandom_range(0, 1));
    end else begin
      send(REQ_UNUSED, c, r, $urandom_range(0, 1));
    end
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned start;
    int unsigned roll;
    start = useful_items;
    while (useful_items - start < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        pattern_burst();
      end else if (roll < 72) begin
        send(REQ_STEP, 0, 0, 1'b0);
        send(REQ_READ, $urandom_range(0, side - 1), $urandom_range(0, side - 1), 1'b0);
      end else if (roll < 90) begin
        send($urandom_range(0, 1) ? REQ_LOAD : REQ_READ, $urandom_range(0, side - 1),
             $urandom_range(0, side - 1), $urandom_range(0, 1));
      end else begin
        noise_item();
      end
    end
  endtask

  task automatic fill_under_hold();
    hold_answers = 1'b1;
    repeat (6) send(REQ_READ, $urandom_range(0, side - 1), $urandom_range(0, side - 1), 1'b0);
  endtask

  // answer side: random stalls, quiet stretches, and a long hold whenever one is asked for
  initial begin
    ans.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_answers) begin
        ans.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_answers = 1'b0;
      end else if (no_idle || $urandom_range(0, 1)) begin
        ans.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        ans.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = GRID_SIZE_RST;
    req.valid      = 1'b0;
    req.req_type   = REQ_LOAD;
    req.col        = '0;
    req.row        = '0;
    req.cell_value = 1'b0;
    no_idle        = 1'b0;
    hold_answers   = 1'b0;
    useful_items   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // cleared grid, then a blinker straddling the column wrap at full size
    send(REQ_READ, 0, 0, 1'b0);
    send(REQ_READ, 63, 63, 1'b0);
    send(REQ_LOAD, 63, 0, 1'b1);
    send(REQ_LOAD, 0, 0, 1'b1);
    send(REQ_LOAD, 1, 0, 1'b1);
    send(REQ_STEP, 0, 0, 1'b0);
    send(REQ_READ, 0, 63, 1'b0);
    send(REQ_READ, 0, 0, 1'b0);
    send(REQ_READ, 0, 1, 1'b0);
    send(REQ_READ, 63, 0, 1'b0);
    send(REQ_READ, 1, 0, 1'b0);
    send(REQ_UNUSED, 63, 63, 1'b1);
    send(REQ_STEP, 63, 63, 1'b1);
    send(REQ_READ, 63, 0, 1'b0);
    send(REQ_LOAD, 63, 63, 1'b1);
    send(REQ_READ, 63, 63, 1'b0);
    send(REQ_LOAD, 63, 63, 1'b0);
    send(REQ_READ, 63, 63, 1'b0);

    foreach (phase_sides[i]) begin
      write_side(phase_sides[i]);
      no_idle = (i % 4 == 2);
      if (i == 3 || i == 7) fill_under_hold();
      run_phase(PHASE_ITEMS);
    end

    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
